// ----- src/tcg_pkg.sv -----
// Shared types, codes and constant tables of the two-channel tone generator.
package tcg_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_FRAME  = 2'd2,
		OP_SAMPLE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SEL_MODE0 = 2'd0,
		SEL_MODE1 = 2'd1,
		SEL_NOTE0 = 2'd2,
		SEL_NOTE1 = 2'd3
	} sel_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] reg_select;
		logic [7:0] write_data;
	} in_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic signed [15:0] sample;
		logic               sound_on;
	} out_t;

	// Work handed from the front part to the back part; turn is a 16-bit turn fraction.
	typedef struct packed {
		logic [7:0]       read_data;
		logic [1:0]       on;
		logic [1:0][15:0] turn;
	} job_t;

	localparam int unsigned SAMPLE_RATE = 48000;
	localparam int unsigned NOTE_COUNT  = 42;
	localparam int unsigned ROM_NOTES   = 42;
	localparam int unsigned NOTE_LAST   =
		((NOTE_COUNT < ROM_NOTES) ? NOTE_COUNT : ROM_NOTES) - 1;
	localparam int unsigned NOTE_IDX_W  = $clog2(ROM_NOTES);
	localparam longint unsigned INC_DEN = 64'd1000 * SAMPLE_RATE;

	localparam logic [20:0] NOTE_MHZ [ROM_NOTES] = '{
		21'd32703,   21'd36708,   21'd41203,   21'd43654,   21'd48999,   21'd55000,
		21'd61735,   21'd65406,   21'd73416,   21'd82407,   21'd87307,   21'd97999,
		21'd110000,  21'd123471,  21'd130813,  21'd146832,  21'd164814,  21'd174614,
		21'd195998,  21'd220000,  21'd246942,  21'd261626,  21'd293665,  21'd329628,
		21'd349228,  21'd391995,  21'd440000,  21'd493883,  21'd523251,  21'd587330,
		21'd659255,  21'd698456,  21'd783991,  21'd880000,  21'd987767,  21'd1046502,
		21'd1174659, 21'd1318510, 21'd1396913, 21'd1567982, 21'd1760000, 21'd1975533
	};

	// Phase step per sample of a note, rounded half up; called with constants only.
	function automatic longint unsigned inc_of(input int unsigned idx,
			input int unsigned phase_bits);
		longint unsigned num;
		num = longint'(NOTE_MHZ[idx]) << phase_bits;
		return (num + INC_DEN / 2) / INC_DEN;
	endfunction

	// Polynomial sine constants, all in fixed point of a quarter turn.
	localparam logic [15:0] SIN_C0  = 16'd42047;
	localparam logic [12:0] SIN_C1  = 13'd4640;
	localparam logic [16:0] SIN_C2  = 17'd102944;
	localparam logic [14:0] QUARTER = 15'd16384;

endpackage

// ----- src/tcg_fifo.sv -----
// Small register-based first-in first-out queue.
module tcg_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ----- src/tcg_front.sv -----
// Front part: register file, mode latch, frame countdown and phase accumulators.
module tcg_front #(
	parameter int unsigned PHASE_BITS     = 24,
	parameter int unsigned SINE_ADDR_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  tcg_pkg::in_t req,
	output logic         job_push,
	output tcg_pkg::job_t job
);
	import tcg_pkg::*;

	logic [PHASE_BITS-1:0] inc_rom [ROM_NOTES];

	for (genvar i = 0; i < ROM_NOTES; i++) begin : g_inc
		assign inc_rom[i] = PHASE_BITS'(inc_of(i, PHASE_BITS));
	end

	logic [7:0]            reg_mode_q [2];
	logic [7:0]            reg_note_q [2];
	logic [7:0]            act_mode_q [2];
	logic [7:0]            act_note_q [2];
	logic [PHASE_BITS-1:0] phase_q    [2];

	logic [7:0]            lat_note   [2];
	logic [PHASE_BITS-1:0] lat_phase  [2];
	logic [PHASE_BITS-1:0] next_phase [2];
	logic [NOTE_IDX_W-1:0] note_idx   [2];
	logic [1:0]            on;
	logic [7:0]            rd_byte;

	// The latch check runs ahead of every item: after it the active mode equals the register.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			if (reg_mode_q[c] != act_mode_q[c]) begin
				lat_note[c]  = reg_note_q[c];
				lat_phase[c] = '0;
			end else begin
				lat_note[c]  = act_note_q[c];
				lat_phase[c] = phase_q[c];
			end
			on[c] = (reg_mode_q[c] != 8'd0);
			note_idx[c] = (lat_note[c] > 8'(NOTE_LAST)) ? NOTE_IDX_W'(NOTE_LAST)
				: lat_note[c][NOTE_IDX_W-1:0];
			next_phase[c] = lat_phase[c] + inc_rom[note_idx[c]];
		end
	end

	always_comb begin
		case (req.reg_select)
			SEL_MODE0: rd_byte = reg_mode_q[0];
			SEL_MODE1: rd_byte = reg_mode_q[1];
			SEL_NOTE0: rd_byte = reg_note_q[0];
			SEL_NOTE1: rd_byte = reg_note_q[1];
			default:   rd_byte = '0;
		endcase
	end

	always_comb begin
		job_push      = item_valid && (req.operation == OP_READ || req.operation == OP_SAMPLE);
		job.read_data = (req.operation == OP_READ) ? rd_byte : 8'd0;
		job.on        = (req.operation == OP_READ) ? 2'b00 : on;
		for (int c = 0; c < 2; c++) begin
			job.turn[c] = 16'(next_phase[c][PHASE_BITS-1 -: SINE_ADDR_BITS])
				<< (16 - SINE_ADDR_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				reg_mode_q[c] <= '0;
				reg_note_q[c] <= '0;
				act_mode_q[c] <= '0;
				act_note_q[c] <= '0;
				phase_q[c]    <= '0;
			end
		end else if (item_valid) begin
			for (int c = 0; c < 2; c++) begin
				act_mode_q[c] <= (req.operation == OP_FRAME && on[c])
					? reg_mode_q[c] - 8'd1 : reg_mode_q[c];
				act_note_q[c] <= lat_note[c];
				phase_q[c]    <= (req.operation == OP_SAMPLE && on[c])
					? next_phase[c] : lat_phase[c];
			end
			case (req.operation)
				OP_WRITE: begin
					case (req.reg_select)
						SEL_MODE0: reg_mode_q[0] <= req.write_data;
						SEL_MODE1: reg_mode_q[1] <= req.write_data;
						SEL_NOTE0: reg_note_q[0] <= req.write_data;
						SEL_NOTE1: reg_note_q[1] <= req.write_data;
						default:   reg_note_q[1] <= reg_note_q[1];
					endcase
				end
				OP_FRAME: begin
					for (int c = 0; c < 2; c++) begin
						if (on[c]) begin
							reg_mode_q[c] <= reg_mode_q[c] - 8'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/tcg_back.sv -----
// Back part: pipelined polynomial sine for both channels, mixing and result credit.
module tcg_back #(
	parameter int unsigned OUT_DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  tcg_pkg::job_t job,
	output logic          job_pop,
	output logic          rsp_push,
	output tcg_pkg::out_t rsp,
	input  logic          rsp_pop
);
	import tcg_pkg::*;

	localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

	logic [CW-1:0] owed_q;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [7:0] rd_s1, rd_s2, rd_s3, rd_s4, rd_s5;
	logic [1:0] on_s1, on_s2, on_s3, on_s4, on_s5;

	logic [1:0]         neg_s1 [2], neg_s2 [2], neg_s3 [2], neg_s4 [2];
	logic [14:0]        z_s1   [2], z_s2   [2], z_s3   [2], z_s4   [2];
	logic [14:0]        z2_s2  [2], z2_s3  [2];
	logic [15:0]        p_s3   [2];
	logic [16:0]        m_s4   [2];
	logic signed [16:0] s_s5   [2];

	logic [14:0]        z_in   [2];
	logic [13:0]        r_in   [2];
	logic [29:0]        zz     [2];
	logic [27:0]        cz     [2];
	logic [30:0]        pz     [2];
	logic [31:0]        zm     [2];
	logic [16:0]        mag    [2];
	logic signed [17:0] sum;
	logic signed [17:0] mix;

	// Results in the pipeline plus those in the output queue never exceed its depth.
	assign job_pop = job_valid && (owed_q < CW'(OUT_DEPTH));

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			r_in[c] = job.turn[c][13:0];
			z_in[c] = job.turn[c][14] ? QUARTER - 15'(r_in[c]) : 15'(r_in[c]);
			zz[c]   = z_s1[c] * z_s1[c];
			cz[c]   = SIN_C1 * z2_s2[c];
			pz[c]   = p_s3[c] * z2_s3[c];
			zm[c]   = z_s4[c] * m_s4[c];
			mag[c]  = zm[c][31:15];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
		end else begin
			owed_q <= owed_q + CW'(job_pop) - CW'(rsp_pop);
			v_s1   <= job_pop;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= job.read_data;
		on_s1 <= job.on;
		rd_s2 <= rd_s1;
		on_s2 <= on_s1;
		rd_s3 <= rd_s2;
		on_s3 <= on_s2;
		rd_s4 <= rd_s3;
		on_s4 <= on_s3;
		rd_s5 <= rd_s4;
		on_s5 <= on_s4;
		for (int c = 0; c < 2; c++) begin
			neg_s1[c] <= job.turn[c][15:14];
			z_s1[c]   <= z_in[c];
			neg_s2[c] <= neg_s1[c];
			z_s2[c]   <= z_s1[c];
			z2_s2[c]  <= zz[c][28:14];
			neg_s3[c] <= neg_s2[c];
			z_s3[c]   <= z_s2[c];
			z2_s3[c]  <= z2_s2[c];
			p_s3[c]   <= SIN_C0 - 16'(cz[c][27:14]);
			neg_s4[c] <= neg_s3[c];
			z_s4[c]   <= z_s3[c];
			m_s4[c]   <= SIN_C2 - pz[c][30:14];
			// The lower half turn is positive, the upper half negative.
			s_s5[c]   <= neg_s4[c][1] ? -$signed(mag[c]) : $signed(mag[c]);
		end
	end

	always_comb begin
		sum = 18'(s_s5[0]) + 18'(s_s5[1]);
		case (on_s5)
			2'b11:   mix = sum >>> 1;
			2'b01:   mix = 18'(s_s5[0]);
			2'b10:   mix = 18'(s_s5[1]);
			default: mix = '0;
		endcase
		rsp_push      = v_s5;
		rsp.read_data = rd_s5;
		rsp.sample    = (mix > 18'sd32767) ? 16'sh7FFF : mix[15:0];
		rsp.sound_on  = (on_s5 != 2'b00);
	end

endmodule

// ----- src/two_channel_tone_generator_unit.sv -----
// Two-channel sine tone generator: front part, work queue, back part and result queue.
// A read or sample-tick result passes through the work queue, the back-part sine pipeline and the result queue.
// One item per cycle while the work queue is not full; the front updates registers and phases as each item is taken.
// Writes and frame ticks give no result and take effect before the next item.
// Reset clears all registers, phases and both queues at once; no clearing pass follows.
module two_channel_tone_generator_unit #(
	parameter int unsigned PHASE_BITS     = 24,
	parameter int unsigned SINE_ADDR_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tcg_pkg::in_t  req,
	output logic          empty,
	input  logic          pop,
	output tcg_pkg::out_t rsp
);
	import tcg_pkg::*;

	localparam int unsigned JOB_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 8;

	logic  accept;
	logic  job_push, job_full, job_empty, job_pop;
	job_t  job_in, job_out;
	logic  rsp_push, rsp_full, rsp_take;
	out_t  rsp_in;

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign rsp_take = pop && !empty;

	tcg_front #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (accept),
		.req        (req),
		.job_push   (job_push),
		.job        (job_in)
	);

	tcg_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	tcg_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.rsp_push  (rsp_push),
		.rsp       (rsp_in),
		.rsp_pop   (rsp_take)
	);

	// The back part holds credit for every slot, so rsp_full never blocks a transfer.
	tcg_fifo #(
		.WIDTH ($bits(out_t)),
		.DEPTH (OUT_DEPTH)
	) u_rsp_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_push && !rsp_full),
		.din    (rsp_in),
		.full   (rsp_full),
		.pop    (pop),
		.dout   (rsp),
		.empty  (empty)
	);

endmodule

// ----- src/tcg_checker.sv -----
// Port-level assertions for the tone generator, bound to the top level.
module tcg_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input tcg_pkg::in_t  req,
	input logic          empty,
	input logic          pop,
	input tcg_pkg::out_t rsp
);
	import tcg_pkg::*;

	// A register read result carries no audio.
	a_read_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.read_data != 8'd0 |-> rsp.sample == 16'sd0 && !rsp.sound_on)
		else $error("read result carries audio");

	// With no channel sounding the sample is zero.
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !rsp.sound_on |-> rsp.sample == 16'sd0)
		else $error("nonzero sample with sound off");

	// A waiting result holds until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(rsp))
		else $error("result changed before transfer");

endmodule

bind two_channel_tone_generator_unit tcg_checker u_tcg_checker (.*);

// ----- tb/tb_two_channel_tone_generator_unit.sv -----
// Self-checking testbench of the two-channel tone generator with a driver, a monitor and a tone predictor.
module tb_two_channel_tone_generator_unit;
	import tcg_pkg::*;

	localparam int unsigned PH_W         = 24;
	localparam int unsigned TABLE_W      = 10;
	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned CHUNKS       = 6;
	localparam int unsigned CHUNK_ITEMS  = 110;
	localparam int unsigned LONG_TONE    = 380;

	typedef struct {
		in_t         item;
		int unsigned gap;
	} pending_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic push   = 1'b0;
	logic pop    = 1'b0;
	in_t  req    = '0;
	logic full;
	logic empty;
	out_t rsp;

	two_channel_tone_generator_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	always #4 clk = ~clk;

	// Predicted register file and channel state.
	logic [7:0]      mode_reg [2];
	logic [7:0]      note_reg [2];
	logic [7:0]      mode_act [2];
	logic [7:0]      note_act [2];
	logic [PH_W-1:0] phase    [2];

	pending_t    pending [$];
	out_t        due_results [$];
	logic        quiet = 1'b0;
	int unsigned gap_left = 0;
	int unsigned pop_wait = 0;
	int unsigned hold_left = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_taken = 0;
	int unsigned idle_cycles = 0;
	int unsigned n_fail = 0;
	int unsigned n_checked = 0;
	int unsigned n_writes = 0;
	int unsigned n_reads = 0;
	int unsigned n_frames = 0;
	int unsigned n_samples = 0;
	int unsigned n_both_on = 0;
	int unsigned n_full_scale = 0;

	function automatic logic [PH_W-1:0] phase_step(input logic [7:0] note);
		int unsigned     idx;
		longint unsigned num;
		longint unsigned den;
		idx = (note > NOTE_LAST) ? NOTE_LAST : note;
		den = 64'd1000 * SAMPLE_RATE;
		num = longint'(NOTE_MHZ[idx]) << PH_W;
		num = (num + den / 2) / den;
		return num[PH_W-1:0];
	endfunction

	// Polynomial sine of the table address, in Q15, -32768..32768.
	function automatic int tone_sine(input logic [PH_W-1:0] ph);
		logic [15:0] turn;
		int unsigned z;
		int unsigned z2;
		int unsigned p;
		int unsigned m;
		int unsigned s;
		turn = {ph[PH_W-1 -: TABLE_W], {(16 - TABLE_W){1'b0}}};
		z    = turn[14] ? 32'd16384 - 32'(turn[13:0]) : 32'(turn[13:0]);
		z2   = (z * z) >> 14;
		p    = 32'd42047 - ((32'd4640 * z2) >> 14);
		m    = 32'd102944 - ((p * z2) >> 14);
		s    = (z * m) >> 15;
		return turn[15] ? -int'(s) : int'(s);
	endfunction

	task automatic predict_tone_item(input in_t it);
		out_t res;
		int   s [2];
		logic on [2];
		int   mix;
		int   c;
		res = '0;
		// A changed mode register restarts its channel before the item acts.
		for (c = 0; c < 2; c++) begin
			if (mode_reg[c] != mode_act[c]) begin
				mode_act[c] = mode_reg[c];
				note_act[c] = note_reg[c];
				phase[c]    = '0;
			end
		end
		case (op_t'(it.operation))
			OP_WRITE: begin
				n_writes++;
				case (sel_t'(it.reg_select))
					SEL_MODE0: mode_reg[0] = it.write_data;
					SEL_MODE1: mode_reg[1] = it.write_data;
					SEL_NOTE0: note_reg[0] = it.write_data;
					SEL_NOTE1: note_reg[1] = it.write_data;
					default: ;
				endcase
			end
			OP_READ: begin
				n_reads++;
				case (sel_t'(it.reg_select))
					SEL_MODE0: res.read_data = mode_reg[0];
					SEL_MODE1: res.read_data = mode_reg[1];
					SEL_NOTE0: res.read_data = note_reg[0];
					SEL_NOTE1: res.read_data = note_reg[1];
					default: ;
				endcase
				due_results.push_back(res);
			end
			OP_FRAME: begin
				n_frames++;
				for (c = 0; c < 2; c++) begin
					if (mode_act[c] != 8'd0) begin
						mode_act[c] = mode_act[c] - 8'd1;
						mode_reg[c] = mode_act[c];
					end
				end
			end
			OP_SAMPLE: begin
				n_samples++;
				for (c = 0; c < 2; c++) begin
					on[c] = (mode_act[c] != 8'd0);
					s[c]  = 0;
					if (on[c]) begin
						phase[c] = phase[c] + phase_step(note_act[c]);
						s[c]     = tone_sine(phase[c]);
					end
				end
				if (on[0] && on[1]) begin
					n_both_on++;
					mix = (s[0] + s[1]) >>> 1;
				end else if (on[0]) begin
					mix = s[0];
				end else if (on[1]) begin
					mix = s[1];
				end else begin
					mix = 0;
				end
				if (mix > 32767) begin
					n_full_scale++;
					mix = 32767;
				end
				res.sample   = mix[15:0];
				res.sound_on = on[0] || on[1];
				due_results.push_back(res);
			end
			default: ;
		endcase
	endtask

	// Driver: one item per transfer, with the item's own gap before it is offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push     <= 1'b0;
			gap_left <= 0;
		end else begin : drive
			pending_t    nxt;
			logic        offer;
			logic        take;
			int unsigned wait_n;
			offer  = push;
			take   = 1'b0;
			wait_n = gap_left;
			if (push && !full) begin
				predict_tone_item(req);
				offer = 1'b0;
				if (pending.size() > 0) begin
					if (pending[0].gap == 0) begin
						take = 1'b1;
					end else begin
						wait_n = pending[0].gap - 1;
					end
				end
			end else if (!push) begin
				if (gap_left > 0) begin
					wait_n = gap_left - 1;
				end else if (pending.size() > 0) begin
					take = 1'b1;
				end
			end
			if (take) begin
				nxt   = pending.pop_front();
				req  <= nxt.item;
				offer = 1'b1;
			end
			push     <= offer;
			gap_left <= wait_n;
		end
	end

	// Monitor: checks every result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop       <= 1'b0;
			pop_wait  <= 0;
			hold_left <= 0;
		end else begin : watch
			out_t        want;
			logic        ready;
			int unsigned w_n;
			int unsigned h_n;
			ready = pop;
			w_n   = pop_wait;
			h_n   = hold_left;
			if (pop && !empty) begin
				n_checked++;
				if (due_results.size() == 0) begin
					$error("result transfer with no prediction waiting");
					n_fail++;
				end else begin
					want = due_results.pop_front();
					if (rsp.read_data !== want.read_data) begin
						$error("read_data: expected %0d, got %0d", want.read_data,
							rsp.read_data);
						n_fail++;
					end
					if (rsp.sample !== want.sample) begin
						$error("sample: expected %0d, got %0d", $signed(want.sample),
							$signed(rsp.sample));
						n_fail++;
					end
					if (rsp.sound_on !== want.sound_on) begin
						$error("sound_on: expected %0d, got %0d", want.sound_on,
							rsp.sound_on);
						n_fail++;
					end
				end
				w_n   = quiet ? 0 : $urandom_range(0, 15);
				ready = (w_n == 0);
				if (w_n > 0) w_n = w_n - 1;
			end else if (!pop) begin
				if (h_n > 0) begin
					h_n = h_n - 1;
				end else if (w_n > 0) begin
					w_n = w_n - 1;
				end else begin
					ready = 1'b1;
				end
			end
			if (holds_taken != hold_requests) begin
				holds_taken <= hold_requests;
				h_n   = HOLD_CYCLES;
				ready = 1'b0;
			end
			pop       <= ready;
			pop_wait  <= w_n;
			hold_left <= h_n;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("tb_two_channel_tone_generator_unit failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic add_item(input op_t op, input sel_t sel, input logic [7:0] data);
		pending_t p;
		p.item.operation  = op;
		p.item.reg_select = sel;
		p.item.write_data = data;
		p.gap             = quiet ? 0 : $urandom_range(0, 15);
		pending.push_back(p);
	endtask

	task automatic add_random_item();
		int unsigned k;
		logic [7:0]  data;
		k = $urandom_range(0, 99);
		if (k < 10) begin
			add_item(op_t'($urandom_range(0, 3)), sel_t'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)));
		end else if (k < 22) begin
			// Mostly short durations so that frame ticks turn channels off again.
			case ($urandom_range(0, 15))
				0, 1:    data = 8'd0;
				2:       data = 8'd255;
				3, 4:    data = 8'($urandom_range(0, 255));
				default: data = 8'($urandom_range(1, 6));
			endcase
			add_item(OP_WRITE, $urandom_range(0, 1) ? SEL_MODE1 : SEL_MODE0, data);
		end else if (k < 32) begin
			data = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, NOTE_LAST));
			add_item(OP_WRITE, $urandom_range(0, 1) ? SEL_NOTE1 : SEL_NOTE0, data);
		end else if (k < 42) begin
			add_item(OP_FRAME, sel_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end else if (k < 57) begin
			add_item(OP_READ, sel_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end else begin
			add_item(OP_SAMPLE, sel_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_sent();
		while (pending.size() != 0 || push) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		int c;
		int i;
		int n;
		for (c = 0; c < 2; c++) begin
			mode_reg[c] = '0;
			note_reg[c] = '0;
			mode_act[c] = '0;
			note_act[c] = '0;
			phase[c]    = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers after reset, a silent tick, both channels, count-down and note saturation.
		add_item(OP_READ, SEL_MODE0, 8'h00);
		add_item(OP_READ, SEL_MODE1, 8'hFF);
		add_item(OP_READ, SEL_NOTE0, 8'h00);
		add_item(OP_READ, SEL_NOTE1, 8'hFF);
		add_item(OP_SAMPLE, SEL_MODE0, 8'h00);
		add_item(OP_WRITE, SEL_NOTE0, 8'd0);
		add_item(OP_WRITE, SEL_MODE0, 8'd255);
		add_item(OP_WRITE, SEL_NOTE1, 8'd255);
		add_item(OP_WRITE, SEL_MODE1, 8'd1);
		add_item(OP_SAMPLE, SEL_NOTE1, 8'h55);
		add_item(OP_SAMPLE, SEL_MODE1, 8'hAA);
		add_item(OP_FRAME, SEL_MODE0, 8'h00);
		add_item(OP_READ, SEL_MODE0, 8'h00);
		add_item(OP_READ, SEL_MODE1, 8'h00);
		add_item(OP_SAMPLE, SEL_MODE0, 8'h00);
		add_item(OP_WRITE, SEL_MODE0, 8'd0);
		add_item(OP_SAMPLE, SEL_MODE0, 8'h00);
		add_item(OP_WRITE, SEL_NOTE1, NOTE_LAST[7:0]);
		add_item(OP_WRITE, SEL_MODE1, 8'd2);
		add_item(OP_SAMPLE, SEL_MODE0, 8'h00);
		add_item(OP_FRAME, SEL_MODE0, 8'h00);
		add_item(OP_FRAME, SEL_MODE0, 8'h00);
		add_item(OP_FRAME, SEL_MODE0, 8'h00);
		add_item(OP_READ, SEL_MODE1, 8'h00);
		add_item(OP_READ, SEL_NOTE1, 8'h00);
		wait_sent();

		// Random traffic in chunks, some of them without any idling on either side.
		for (n = 0; n < CHUNKS; n++) begin
			quiet = ($urandom_range(0, 2) == 0);
			for (i = 0; i < CHUNK_ITEMS; i++) add_random_item();
			wait_sent();
		end

		// A long single-channel tone on the lowest note while the receiver holds off;
		// it reaches a quarter turn, where the sine hits full scale.
		quiet = 1'b1;
		hold_requests++;
		add_item(OP_WRITE, SEL_MODE0, 8'd0);
		add_item(OP_WRITE, SEL_MODE1, 8'd0);
		add_item(OP_WRITE, SEL_NOTE0, 8'd0);
		add_item(OP_WRITE, SEL_MODE0, 8'd200);
		for (i = 0; i < LONG_TONE; i++) add_item(OP_SAMPLE, SEL_MODE0, 8'($urandom_range(0, 255)));
		wait_sent();
		quiet = 1'b0;

		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Items: %0d writes, %0d reads, %0d frame ticks, %0d sample ticks.",
			n_writes, n_reads, n_frames, n_samples);
		$display("Results checked: %0d; mixes of both channels: %0d; full-scale samples: %0d.",
			n_checked, n_both_on, n_full_scale);
		if (n_fail == 0) begin
			$display("tb_two_channel_tone_generator_unit passed");
		end else begin
			$display("tb_two_channel_tone_generator_unit failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/tcg_pkg.sv
src/tcg_fifo.sv
src/tcg_front.sv
src/tcg_back.sv
src/two_channel_tone_generator_unit.sv
src/tcg_checker.sv
tb/tb_two_channel_tone_generator_unit.sv
